FILE: src/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared codes and constants for the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package slc_pkg;

    typedef enum logic [1:0]
    {
        OP_FETCH  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_STORE  = 2'd2,
        OP_MODIFY = 2'd3
    } opcode_t;

    typedef enum logic [1:0]
    {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_index_t;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int BLOCK_CFG_W = 6;
    localparam int SET_CFG_W = 4;
    localparam int WAYS_CFG_W = 4;
    localparam int BLOCK_MAX = 32;

    typedef enum logic [1:0]
    {
        ST_RD = 2'b01,
        ST_EX = 2'b10
    } back_state_t;

endpackage

FILE: src/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Trace-driven set-associative cache hit/miss model with LRU replacement.
// ----------------------------------------------------------------------------
// Each input word carries an opcode and a byte address. Fetches are taken and
// dropped; loads and stores give one result word, modifies give two (the
// second with tlast set). Each access takes two steps in the back end: one
// to read the set row from the tag and LRU memories, one to compare, pick
// the way and write the row back; a new access starts only after the row
// is written back. The front end splits addresses and queues accesses in a
// two-word FIFO, so it takes new words while the back end works and while a
// result waits on the output register, until the FIFO fills. Line state is
// cleared at reset by one flag per set; no clearing pass is needed. Result
// totals show the saturating counters after the access. Configuration writes
// are taken at any time but are meant for idle periods; set and ways fields
// keep their low four bits; out-of-range fields are clamped to their bounds.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic clk,
    input  logic rst_n,
    // opcode [1:0], address [ADDR_WIDTH+1:2], zero fill
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((ADDR_WIDTH+2+7)/8)*8-1:0]    s_axis_tdata,
    // hit [0], evicted [1], hit_total [33:2], miss_total [65:34],
    // evict_total [97:66], zero fill
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [103:0]                         m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [5:0]                           cfg_data
);
    import slc_pkg::*;

    localparam int TAG_W   = ADDR_WIDTH - 2;
    localparam int SBITS_W = $clog2(MAX_SET_BITS + 1);
    localparam int WAYS_W  = $clog2(MAX_WAYS + 1);

    logic [SET_CFG_W-1:0]   set_cfg_reg;
    logic [BLOCK_CFG_W-1:0] blk_cfg_reg;
    logic [WAYS_CFG_W-1:0]  way_cfg_reg;
    logic [SBITS_W-1:0]     set_bits;
    logic [BLOCK_CFG_W-1:0] block_bits;
    logic [WAYS_W-1:0]      ways;

    logic                    q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [TAG_W-1:0]        f_tag;
    logic [MAX_SET_BITS-1:0] f_set;
    logic                    f_last;
    logic [TAG_W+MAX_SET_BITS:0] q_word;

    logic              o_hit, o_evicted;
    logic [CNT_W-1:0]  o_hits, o_misses, o_evicts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_cfg_reg <= SET_CFG_W'(4);
            blk_cfg_reg <= BLOCK_CFG_W'(4);
            way_cfg_reg <= WAYS_CFG_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_cfg_reg <= cfg_data[SET_CFG_W-1:0];
                CFG_BLOCK_BITS: blk_cfg_reg <= cfg_data;
                CFG_WAYS:       way_cfg_reg <= cfg_data[WAYS_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // clamp each field to its meaningful range
    always_comb
    begin
        if (set_cfg_reg == '0)
            set_bits = SBITS_W'(1);
        else if (int'(set_cfg_reg) > MAX_SET_BITS)
            set_bits = SBITS_W'(MAX_SET_BITS);
        else
            set_bits = SBITS_W'(set_cfg_reg);
        if (blk_cfg_reg == '0)
            block_bits = BLOCK_CFG_W'(1);
        else if (int'(blk_cfg_reg) > BLOCK_MAX)
            block_bits = BLOCK_CFG_W'(BLOCK_MAX);
        else
            block_bits = blk_cfg_reg;
        if (way_cfg_reg == '0)
            ways = WAYS_W'(1);
        else if (int'(way_cfg_reg) > MAX_WAYS)
            ways = WAYS_W'(MAX_WAYS);
        else
            ways = WAYS_W'(way_cfg_reg);
    end

    slc_front #(
        .ADDR_WIDTH   (ADDR_WIDTH),
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_opcode  (s_axis_tdata[1:0]),
        .in_address (s_axis_tdata[ADDR_WIDTH+1:2]),
        .set_bits   (set_bits),
        .block_bits (block_bits),
        .q_valid    (q_in_valid),
        .q_ready    (q_in_ready),
        .q_tag      (f_tag),
        .q_set      (f_set),
        .q_last     (f_last)
    );

    slc_queue #(
        .W (TAG_W + MAX_SET_BITS + 1)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  ({f_last, f_set, f_tag}),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_word)
    );

    slc_back #(
        .ADDR_WIDTH   (ADDR_WIDTH),
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_out_valid),
        .q_ready     (q_out_ready),
        .q_tag       (q_word[TAG_W-1:0]),
        .q_set       (q_word[TAG_W +: MAX_SET_BITS]),
        .q_last      (q_word[TAG_W+MAX_SET_BITS]),
        .ways        (ways),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_hit     (o_hit),
        .out_evicted (o_evicted),
        .out_last    (m_axis_tlast),
        .out_hits    (o_hits),
        .out_misses  (o_misses),
        .out_evicts  (o_evicts)
    );

    assign m_axis_tdata = {6'd0, o_evicts, o_misses, o_hits, o_evicted, o_hit};
endmodule

FILE: src/slc_queue.sv
// ----------------------------------------------------------------------------
// slc_queue
// Two-word FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module slc_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next;
    logic         rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

FILE: src/slc_front.sv
// ----------------------------------------------------------------------------
// slc_front
// Accepts trace words, splits the address and issues one access per load or store, two per modify, none per fetch.
// ----------------------------------------------------------------------------
module slc_front #(
    parameter int ADDR_WIDTH   = 64,
    parameter int MAX_SET_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_opcode,
    input  logic [ADDR_WIDTH-1:0]         in_address,
    input  logic [$clog2(MAX_SET_BITS+1)-1:0] set_bits,
    input  logic [slc_pkg::BLOCK_CFG_W-1:0]   block_bits,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [ADDR_WIDTH-3:0]         q_tag,
    output logic [MAX_SET_BITS-1:0]       q_set,
    output logic                          q_last
);
    import slc_pkg::*;

    localparam int TAG_W = ADDR_WIDTH - 2;
    localparam int SH_W  = $clog2(MAX_SET_BITS + BLOCK_MAX + 1);

    logic                    pend_reg, pend_next;
    logic                    two_reg, two_next;
    logic [TAG_W-1:0]        tag_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [ADDR_WIDTH-1:0]   tag_shift, set_shift;
    logic [MAX_SET_BITS-1:0] set_mask;
    logic [SH_W-1:0]         shamt;
    logic                    take;

    assign in_ready = !pend_reg;
    assign take     = in_valid && in_ready && (opcode_t'(in_opcode) != OP_FETCH);
    assign q_valid  = pend_reg;
    assign q_tag    = tag_reg;
    assign q_set    = set_reg;
    assign q_last   = !two_reg;

    always_comb
    begin
        shamt     = SH_W'(set_bits) + SH_W'(block_bits);
        tag_shift = in_address >> shamt;
        set_shift = in_address >> block_bits;
        set_mask  = ~({MAX_SET_BITS{1'b1}} << set_bits);
        pend_next = pend_reg;
        two_next  = two_reg;
        if (take)
        begin
            pend_next = 1'b1;
            two_next  = (opcode_t'(in_opcode) == OP_MODIFY);
        end
        else if (pend_reg && q_ready)
        begin
            if (two_reg)
            begin
                two_next = 1'b0;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            two_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            two_reg  <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tag_reg <= tag_shift[TAG_W-1:0];
            set_reg <= set_shift[MAX_SET_BITS-1:0] & set_mask;
        end
    end
endmodule

FILE: src/slc_back.sv
// ----------------------------------------------------------------------------
// slc_back
// Set lookup, LRU update, replacement and counters; one access at a time.
// ----------------------------------------------------------------------------
module slc_back #(
    parameter int ADDR_WIDTH   = 64,
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  logic [ADDR_WIDTH-3:0]             q_tag,
    input  logic [MAX_SET_BITS-1:0]           q_set,
    input  logic                              q_last,
    input  logic [$clog2(MAX_WAYS+1)-1:0]     ways,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_hit,
    output logic                              out_evicted,
    output logic                              out_last,
    output logic [slc_pkg::CNT_W-1:0]         out_hits,
    output logic [slc_pkg::CNT_W-1:0]         out_misses,
    output logic [slc_pkg::CNT_W-1:0]         out_evicts
);
    import slc_pkg::*;

    localparam int TAG_W  = ADDR_WIDTH - 2;
    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNTV_W = $clog2(MAX_WAYS + 1);

    // set memories
    logic [MAX_WAYS*TAG_W-1:0]  tag_mem  [NSETS];
    logic [MAX_WAYS*RANK_W-1:0] rank_mem [NSETS];
    logic [MAX_WAYS-1:0]        vld_mem  [NSETS];
    logic [NSETS-1:0]           row_ok_reg;

    logic [MAX_WAYS*TAG_W-1:0]  tag_rd_reg;
    logic [MAX_WAYS*RANK_W-1:0] rank_rd_reg;
    logic [MAX_WAYS-1:0]        vld_rd_reg;
    logic                       ok_rd_reg;

    logic [TAG_W-1:0]           cur_tag_reg;
    logic [MAX_SET_BITS-1:0]    cur_set_reg;
    logic                       cur_last_reg;

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0] hits_reg, misses_reg, evicts_reg;
    logic             ov_reg;

    // lookup
    logic [MAX_WAYS-1:0]       vld, vld_new;
    logic [RANK_W-1:0]         rank [MAX_WAYS];
    logic [MAX_WAYS*RANK_W-1:0] rank_new;
    logic [MAX_WAYS*TAG_W-1:0] tag_new;
    logic                      hit_any, free_any, vic_any, do_fill, do_evict;
    logic [RANK_W-1:0]         hit_way, free_way, vic_way, tgt, vic_rank;
    logic [RANK_W:0]           old;
    logic [CNTV_W-1:0]         nvalid;
    logic                      fire_ex;

    assign q_ready   = (state_reg == ST_RD);
    assign fire_ex   = (state_reg == ST_EX) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        vld      = ok_rd_reg ? vld_rd_reg : '0;
        hit_any  = 1'b0;
        free_any = 1'b0;
        vic_any  = 1'b0;
        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        vic_rank = '0;
        nvalid   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            rank[w] = ok_rd_reg ? rank_rd_reg[w*RANK_W +: RANK_W] : '0;
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (vld[w])
            begin
                nvalid = nvalid + 1'b1;
                if (!hit_any && tag_rd_reg[w*TAG_W +: TAG_W] == cur_tag_reg)
                begin
                    hit_any = 1'b1;
                    hit_way = RANK_W'(w);
                end
                if (!vic_any || rank[w] > vic_rank)
                begin
                    vic_any  = 1'b1;
                    vic_rank = rank[w];
                    vic_way  = RANK_W'(w);
                end
            end
            else if (!free_any)
            begin
                free_any = 1'b1;
                free_way = RANK_W'(w);
            end
        end
        do_fill  = !hit_any && (nvalid < ways) && free_any;
        do_evict = !hit_any && !do_fill;
        priority if (hit_any)
        begin
            tgt = hit_way;
        end
        else if (do_fill)
        begin
            tgt = free_way;
        end
        else
        begin
            tgt = vic_way;
        end
        // a fresh line pushes every valid line down one place
        old = do_fill ? (RANK_W+1)'(MAX_WAYS) : {1'b0, rank[tgt]};
        vld_new = vld;
        vld_new[tgt] = 1'b1;
        tag_new = tag_rd_reg;
        tag_new[tgt*TAG_W +: TAG_W] = cur_tag_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (RANK_W'(w) == tgt)
            begin
                rank_new[w*RANK_W +: RANK_W] = '0;
            end
            else if (vld[w] && ({1'b0, rank[w]} < old))
            begin
                rank_new[w*RANK_W +: RANK_W] = rank[w] + 1'b1;
            end
            else
            begin
                rank_new[w*RANK_W +: RANK_W] = rank[w];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RD:
            begin
                if (q_valid)
                begin
                    state_next = ST_EX;
                end
            end
            ST_EX:
            begin
                if (fire_ex)
                begin
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_RD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RD;
            row_ok_reg <= '0;
            ov_reg     <= 1'b0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (fire_ex)
            begin
                ov_reg <= 1'b1;
                row_ok_reg[cur_set_reg] <= 1'b1;
                if (hit_any)
                begin
                    hits_reg <= (hits_reg == CNT_MAX) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_reg <= (misses_reg == CNT_MAX) ? misses_reg : misses_reg + 1'b1;
                end
                if (do_evict)
                begin
                    evicts_reg <= (evicts_reg == CNT_MAX) ? evicts_reg : evicts_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cur_tag_reg  <= q_tag;
            cur_set_reg  <= q_set;
            cur_last_reg <= q_last;
            tag_rd_reg   <= tag_mem[q_set];
            rank_rd_reg  <= rank_mem[q_set];
            vld_rd_reg   <= vld_mem[q_set];
            ok_rd_reg    <= row_ok_reg[q_set];
        end
        if (fire_ex)
        begin
            tag_mem[cur_set_reg]  <= tag_new;
            rank_mem[cur_set_reg] <= rank_new;
            vld_mem[cur_set_reg]  <= vld_new;
            out_hit     <= hit_any;
            out_evicted <= do_evict;
            out_last    <= cur_last_reg;
        end
    end

    // totals are registered, so the word shows the counts after its access
    assign out_hits   = hits_reg;
    assign out_misses = misses_reg;
    assign out_evicts = evicts_reg;
endmodule

FILE: src/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks on the cache simulator's result stream.
// ----------------------------------------------------------------------------
module slc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
        else $error("hit flagged with eviction");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[33:2] != 32'd0)
        else $error("hit with zero hit total");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[65:34] != 32'd0)
        else $error("miss with zero miss total");

    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[97:66] != 32'd0)
        else $error("eviction with zero eviction total");
endmodule

bind set_assoc_lru_cache_sim slc_checker u_slc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
